FILE: hdl/npcm_pkg.sv
// Package for the nearest palette colour mapper.
// Types, constants and helper functions used by the controller, datapath and top level.
// No dependencies.
package npcm_pkg;

    localparam int PAL_DEPTH      = 256;
    localparam int PAL_AW         = $clog2(PAL_DEPTH);
    localparam int SIZE_W         = 9;
    localparam int COLOR_W        = 8;
    localparam int RGB_W          = 3 * COLOR_W;
    localparam int SQR_W          = 2 * COLOR_W;
    localparam int SUM_W          = SQR_W + 3;
    localparam int KEY_W          = COLOR_W + 1;
    localparam int SQRT_STEPS     = 9;
    localparam int SQRT_PER_STAGE = 3;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic              wr_en;
        logic              start;
        logic              rd_en;
        logic [PAL_AW-1:0] rd_addr;
        logic              load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
    } sqrt_acc_t;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Three digit-by-digit square root steps, starting at step first_step.
    function automatic sqrt_acc_t sqrt_steps(input sqrt_acc_t acc_in, input int first_step);
        sqrt_acc_t        acc;
        logic [SUM_W-1:0] bit_val;
        logic [SUM_W-1:0] trial;
        acc = acc_in;
        for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            bit_val = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - (first_step + j)));
            trial   = acc.root + bit_val;
            if (acc.rem >= trial) begin
                acc.rem  = acc.rem - trial;
                acc.root = (acc.root >> 1) + bit_val;
            end
            else begin
                acc.root = acc.root >> 1;
            end
        end
        sqrt_steps = acc;
    endfunction

endpackage

FILE: hdl/nearest_palette_color_mapper_core.sv
// Nearest palette colour mapper, top level: streaming ports around npcm_ctrl and
// npcm_datapath. Uses npcm_pkg.
//
// Load transfers (tuser 0) write one palette entry. A pixel transfer (tuser 1) is
// compared against palette entries 0 to palette_size-1 by floor of the Euclidean RGB
// distance, lowest index winning ties, and returns that entry's colour (black for an
// empty palette); sizes above 256 are treated as 256. For a pixel, one entry is read
// per cycle from the palette memory, followed by the drain of the distance and
// square root pipeline. Results sit in an output register, so new transfers are
// taken while a result waits. Entries 0 to palette_size-1 must all be written before a
// pixel is sent.
module nearest_palette_color_mapper_core
    import npcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,   // palette_size
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,    // entry_index, in_red, in_green, in_blue
    input  logic [0:0]        s_tuser,    // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata     // out_red, out_green, out_blue
);

    dp_cmd_t    cmd;
    dp_status_t status;

    npcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    npcm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (s_tdata[7:0]),
        .in_red      (s_tdata[15:8]),
        .in_green    (s_tdata[23:16]),
        .in_blue     (s_tdata[31:24]),
        .out_red     (m_tdata[7:0]),
        .out_green   (m_tdata[15:8]),
        .out_blue    (m_tdata[23:16])
    );

endmodule

FILE: hdl/npcm_ctrl.sv
// Controller state machine for the nearest palette colour mapper.
// Sequences loads, the palette scan, pipeline drain and result hand-off. Uses npcm_pkg.
module npcm_ctrl
    import npcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              req_type,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dp_cmd_t           cmd,
    input  dp_status_t        status
);

    ctrl_state_t       state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] count;
    logic              accept;
    req_kind_t         kind;

    assign cfg_ready = 1'b1;
    assign count     = (size_reg > SIZE_W'(PAL_DEPTH)) ? SIZE_W'(PAL_DEPTH) : size_reg;
    assign kind      = req_kind_t'(req_type);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            size_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                addr_next = '0;
                if (accept && kind == REQ_PIXEL) begin
                    state_next = (count == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                addr_next = addr_reg + SIZE_W'(1);
                if (addr_reg == count - SIZE_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.rd_addr  = addr_reg[PAL_AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.wr_en = accept && kind == REQ_LOAD;
                cmd.start = accept && kind == REQ_PIXEL;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_RESULT: begin
                cmd.load_out = !out_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end
        else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

endmodule

FILE: hdl/npcm_datapath.sv
// Datapath for the nearest palette colour mapper: palette memory, distance and
// square root pipeline, best-match tracking and output register. Uses npcm_pkg.
module npcm_datapath
    import npcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [PAL_AW-1:0]  entry_index,
    input  logic [COLOR_W-1:0] in_red,
    input  logic [COLOR_W-1:0] in_green,
    input  logic [COLOR_W-1:0] in_blue,
    output logic [COLOR_W-1:0] out_red,
    output logic [COLOR_W-1:0] out_green,
    output logic [COLOR_W-1:0] out_blue
);

    logic [RGB_W-1:0]   mem [PAL_DEPTH];
    logic [RGB_W-1:0]   rd_data_reg;
    logic [COLOR_W-1:0] px_r_reg, px_g_reg, px_b_reg;

    logic [SQR_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [RGB_W-1:0]   col1_reg, col2_reg;
    logic [SUM_W-1:0]   sum_reg;
    sqrt_acc_t          acc_reg [SQRT_STAGES];
    logic [RGB_W-1:0]   sq_col_reg [SQRT_STAGES];

    logic               v0_reg, v1_reg, v2_reg;
    logic [SQRT_STAGES-1:0] sv_reg;

    logic               have_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [RGB_W-1:0]   best_col_reg;
    logic [RGB_W-1:0]   out_col_reg;
    logic [KEY_W-1:0]   key;
    logic [COLOR_W-1:0] e_r, e_g, e_b;
    logic [COLOR_W-1:0] d_r, d_g, d_b;
    sqrt_acc_t          acc_first;

    // palette memory, registered read
    always_ff @(posedge clk) begin
        if (cmd.wr_en) begin
            mem[entry_index] <= {in_red, in_green, in_blue};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sv_reg   <= '0;
            have_reg <= 1'b0;
        end
        else begin
            v0_reg <= cmd.rd_en;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            sv_reg <= {sv_reg[SQRT_STAGES-2:0], v2_reg};
            if (cmd.start) begin
                have_reg <= 1'b0;
            end
            else if (sv_reg[SQRT_STAGES-1]) begin
                have_reg <= 1'b1;
            end
        end
    end

    assign e_r = rd_data_reg[RGB_W-1 -: COLOR_W];
    assign e_g = rd_data_reg[SQR_W-1 -: COLOR_W];
    assign e_b = rd_data_reg[COLOR_W-1:0];
    assign d_r = abs_diff(e_r, px_r_reg);
    assign d_g = abs_diff(e_g, px_g_reg);
    assign d_b = abs_diff(e_b, px_b_reg);

    assign acc_first.rem  = sum_reg;
    assign acc_first.root = '0;

    assign key = acc_reg[SQRT_STAGES-1].root[KEY_W-1:0];

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            px_r_reg <= in_red;
            px_g_reg <= in_green;
            px_b_reg <= in_blue;
        end
        sq_r_reg <= SQR_W'(d_r) * SQR_W'(d_r);
        sq_g_reg <= SQR_W'(d_g) * SQR_W'(d_g);
        sq_b_reg <= SQR_W'(d_b) * SQR_W'(d_b);
        col1_reg <= rd_data_reg;
        sum_reg  <= SUM_W'(sq_r_reg) + SUM_W'(sq_g_reg) + SUM_W'(sq_b_reg);
        col2_reg <= col1_reg;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                acc_reg[s]    <= sqrt_steps(acc_first, 0);
                sq_col_reg[s] <= col2_reg;
            end
            else begin
                acc_reg[s]    <= sqrt_steps(acc_reg[s-1], s * SQRT_PER_STAGE);
                sq_col_reg[s] <= sq_col_reg[s-1];
            end
        end
        // strictly smaller key wins, so the lowest index keeps ties
        if (cmd.start) begin
            best_col_reg <= '0;
            best_key_reg <= '0;
        end
        else if (sv_reg[SQRT_STAGES-1] && (!have_reg || key < best_key_reg)) begin
            best_col_reg <= sq_col_reg[SQRT_STAGES-1];
            best_key_reg <= key;
        end
        if (cmd.load_out) begin
            out_col_reg <= best_col_reg;
        end
    end

    assign status.busy = v0_reg || v1_reg || v2_reg || (|sv_reg);

    assign out_red   = out_col_reg[RGB_W-1 -: COLOR_W];
    assign out_green = out_col_reg[SQR_W-1 -: COLOR_W];
    assign out_blue  = out_col_reg[COLOR_W-1:0];

endmodule

FILE: dv/palette_map_checker.sv
// Checker for nearest_palette_color_mapper_core: watches the config, input and result channels,
// keeps its own palette copy and predicts each pixel's nearest colour. Uses npcm_pkg.
// Reports a running mismatch count and the number of results still owed.
module palette_map_checker
    import npcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } colour_t;

    colour_t           palette_copy [PAL_DEPTH];
    logic [SIZE_W-1:0] size_reg = '0;
    colour_t           expected_colours [$];

    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 512;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic colour_t nearest_entry_colour(input colour_t px);
        int      count;
        int      dr;
        int      dg;
        int      db;
        int      dist_key;
        int      best_key;
        colour_t best;
        count    = (size_reg > PAL_DEPTH) ? PAL_DEPTH : int'(size_reg);
        best     = '0;
        best_key = 0;
        for (int i = 0; i < count; i++)
        begin
            dr       = int'(palette_copy[i].red) - int'(px.red);
            dg       = int'(palette_copy[i].green) - int'(px.green);
            db       = int'(palette_copy[i].blue) - int'(px.blue);
            dist_key = int'(floor_root(dr * dr + dg * dg + db * db));
            // strict compare: lowest index keeps a tie
            if (i == 0 || dist_key < best_key)
            begin
                best_key = dist_key;
                best     = palette_copy[i];
            end
        end
        return best;
    endfunction

    task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                               input logic [COLOR_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        colour_t want;
        colour_t px;
        if (!rst_n)
        begin
            size_reg = '0;
            expected_colours.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_colours.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                end
                else
                begin
                    want = expected_colours.pop_front();
                    check_field("out_red", want.red, m_tdata[7:0]);
                    check_field("out_green", want.green, m_tdata[15:8]);
                    check_field("out_blue", want.blue, m_tdata[23:16]);
                end
            end
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                px.red   = s_tdata[15:8];
                px.green = s_tdata[23:16];
                px.blue  = s_tdata[31:24];
                if (req_kind_t'(s_tuser[0]) == REQ_LOAD)
                    palette_copy[s_tdata[7:0]] = px;
                else
                    expected_colours = {expected_colours, nearest_entry_colour(px)};
            end
            outstanding <= expected_colours.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the palette mapper testbench: clock, reset, load/pixel stimulus, palette size
// changes and the verdict. Depends on npcm_pkg, nearest_palette_color_mapper_core and
// palette_map_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import npcm_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 30;
    localparam int ITEM_TARGET   = 1035;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;

    int mismatches;
    int outstanding;
    int quiet_cycles  = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 67;
    int sent_items    = 0;
    int active_size   = 0;

    logic [23:0] palette_colour [PAL_DEPTH];
    bit          loaded [PAL_DEPTH];

    nearest_palette_color_mapper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    palette_map_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_item(input req_kind_t kind, input logic [7:0] idx, input logic [23:0] rgb);
        send_idle_pct = (sent_items < 350) ? 19 : (sent_items < 700) ? 67 : 0;
        recv_idle_pct = (sent_items < 350) ? 67 : (sent_items < 700) ? 19 : 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == REQ_LOAD)
        begin
            palette_colour[idx] = rgb;
            loaded[idx]         = 1'b1;
        end
        sent_items++;
    endtask

    // hold off the sender until every result owed has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_palette_size(input int size);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= size[SIZE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        active_size = size;
    endtask

    function automatic logic [7:0] nudge(input logic [7:0] c);
        int t;
        t = int'(c) + int'($urandom_range(6)) - 3;
        return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[7:0];
    endfunction

    task automatic random_load();
        logic [7:0]  idx;
        logic [23:0] rgb;
        idx = 8'($urandom_range(255));
        rgb = 24'($urandom);
        if ($urandom_range(3) == 0 && loaded[rgb[7:0]])
            rgb = palette_colour[rgb[7:0]];
        push_item(REQ_LOAD, idx, rgb);
    endtask

    task automatic random_pixel();
        int          pick;
        int          in_use;
        logic [23:0] rgb;
        logic [23:0] base;
        in_use = (active_size > PAL_DEPTH) ? PAL_DEPTH : active_size;
        pick   = $urandom_range(99);
        rgb    = 24'($urandom);
        if (in_use > 0 && pick < 45)
        begin
            base = palette_colour[$urandom_range(in_use - 1)];
            rgb  = (pick < 15) ? base : {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
        end
        else if (pick < 60)
        begin
            for (int k = 0; k < 24; k += 8)
                rgb[k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        push_item(REQ_PIXEL, 8'($urandom), rgb);
    endtask

    task automatic run_phase(input int size, input int n_items);
        write_palette_size(size);
        for (int i = 0; i < ((size > PAL_DEPTH) ? PAL_DEPTH : size); i++)
            if (!loaded[i])
                push_item(REQ_LOAD, i[7:0], 24'($urandom));
        repeat (n_items)
        begin
            if ($urandom_range(99) < 20)
                random_load();
            else
                random_pixel();
        end
    endtask

    initial
    begin
        int phase;
        int size;
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty palette gives black
        write_palette_size(0);
        push_item(REQ_PIXEL, 8'hFF, 24'h000000);
        push_item(REQ_PIXEL, 8'h00, 24'hFFFFFF);

        // duplicates for index ties, and two entries with one truncated key
        push_item(REQ_LOAD, 8'd0, 24'h000000);
        push_item(REQ_LOAD, 8'd1, 24'hFFFFFF);
        push_item(REQ_LOAD, 8'd2, 24'hFF0000);
        push_item(REQ_LOAD, 8'd3, 24'hFFFFFF);
        push_item(REQ_LOAD, 8'd4, {8'd101, 8'd101, 8'd100});
        push_item(REQ_LOAD, 8'd5, {8'd100, 8'd100, 8'd101});
        push_item(REQ_LOAD, 8'd255, 24'h00FFFF);
        write_palette_size(6);
        push_item(REQ_PIXEL, 8'hAA, 24'h000000);
        push_item(REQ_PIXEL, 8'h55, 24'hFFFFFF);
        push_item(REQ_PIXEL, 8'hAA, {8'd250, 8'd5, 8'd5});
        push_item(REQ_PIXEL, 8'h55, {8'd100, 8'd100, 8'd100});
        push_item(REQ_PIXEL, 8'hFF, 24'h00FFFF);
        push_item(REQ_PIXEL, 8'h00, 24'h808080);

        phase = 0;
        while (sent_items < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (phase == 0)
                size = PAL_DEPTH;
            else if (phase == 1)
                size = 511;
            else if (phase == 2)
                size = 1;
            else if (pick < 8)
                size = 0;
            else if (pick < 14)
                size = PAL_DEPTH;
            else if (pick < 19)
                size = $urandom_range(511, PAL_DEPTH + 1);
            else
                size = $urandom_range(40, 1);
            run_phase(size, (size >= PAL_DEPTH) ? 10 : $urandom_range(45, 20));
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: nearest_palette_color_mapper_core.f
hdl/npcm_pkg.sv
hdl/npcm_ctrl.sv
hdl/npcm_datapath.sv
hdl/nearest_palette_color_mapper_core.sv
dv/palette_map_checker.sv
dv/testbench.sv
